>>> design/assert_macros.svh
// Assertion macros shared by the running max drawdown RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define RMDD_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled in reset.
`define RMDD_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> design/rmdd_pkg.sv
// Package for the running max drawdown block: widths, constants, FSM state,
// and controller/datapath command and status types. No dependencies.
package rmdd_pkg;

  localparam int CAPITAL_BITS     = 48;
  localparam int RETURN_FRAC_BITS = 24;
  localparam int RETURN_BITS      = 32;
  localparam int DRAWDOWN_BITS    = 32;
  localparam int INIT_BITS        = 47;
  localparam logic [INIT_BITS-1:0] INIT_RESET = 47'd65536000;

  localparam int PADDR_W = 4;
  localparam int PDATA_W = 64;
  localparam logic [PADDR_W-4:0] REG_INITIAL_CAPITAL = 1'd0;

  localparam int FMAG_BITS = 32;
  localparam int STEPS     = 32;
  localparam int CNT_W     = $clog2(STEPS);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_ROUND,
    ST_SAT,
    ST_SCALE,
    ST_PRE,
    ST_DIV,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic start;
    logic mul_step;
    logic round;
    logic sat;
    logic scale;
    logic pre;
    logic div_step;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic out_full;
  } status_t;

endpackage

>>> design/rmdd_trade_if.sv
// Input channel: one trade return per transfer.
// Depends on rmdd_pkg.
interface rmdd_trade_if;
  logic                                     valid;
  logic                                     ready;
  logic signed [rmdd_pkg::RETURN_BITS-1:0]  trade_return;
  logic                                     first_of_series;

  modport source (output valid, output trade_return, output first_of_series, input ready);
  modport sink   (input valid, input trade_return, input first_of_series, output ready);
endinterface

>>> design/rmdd_result_if.sv
// Output channel: compounded capital and running max drawdown per transfer.
// Depends on rmdd_pkg.
interface rmdd_result_if #(
  parameter int CAPITAL_BITS = rmdd_pkg::CAPITAL_BITS
);
  logic                                     valid;
  logic                                     ready;
  logic signed [CAPITAL_BITS-1:0]           capital_now;
  logic        [rmdd_pkg::DRAWDOWN_BITS-1:0] max_drawdown;

  modport source (output valid, output capital_now, output max_drawdown, input ready);
  modport sink   (input valid, input capital_now, input max_drawdown, output ready);
endinterface

>>> design/rmdd_cfg.sv
// APB-style register file holding initial_capital.
// Depends on rmdd_pkg.
module rmdd_cfg (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [rmdd_pkg::PADDR_W-1:0]     paddr,
  input  logic [rmdd_pkg::PDATA_W-1:0]     pwdata,
  output logic [rmdd_pkg::PDATA_W-1:0]     prdata,
  output logic                             pready,
  output logic [rmdd_pkg::INIT_BITS-1:0]   initial_capital
);

  logic                               hit;
  logic [rmdd_pkg::PADDR_W-4:0]       reg_index;

  // paddr[2:0] are byte lanes within the 8-byte register
  assign reg_index = paddr[rmdd_pkg::PADDR_W-1:3];
  assign hit       = (reg_index == rmdd_pkg::REG_INITIAL_CAPITAL);
  assign pready    = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      initial_capital <= rmdd_pkg::INIT_RESET;
    end else if (psel && penable && pwrite && hit) begin
      initial_capital <= pwdata[rmdd_pkg::INIT_BITS-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (psel && hit) begin
      prdata = rmdd_pkg::PDATA_W'(initial_capital);
    end
  end

endmodule

>>> design/rmdd_ctrl.sv
// Sequencer for the drawdown datapath: serial multiply, round, saturate,
// scale, restoring divide, result write. Depends on rmdd_pkg.
module rmdd_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  rmdd_pkg::status_t status,
  output rmdd_pkg::cmd_t    cmd
);

  rmdd_pkg::state_t               state, state_next;
  logic [rmdd_pkg::CNT_W-1:0]     cnt, cnt_next;
  logic                           cnt_last;

  assign cnt_last = (cnt == rmdd_pkg::CNT_W'(rmdd_pkg::STEPS - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rmdd_pkg::ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      rmdd_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.start  = 1'b1;
          cnt_next   = '0;
          state_next = rmdd_pkg::ST_MUL;
        end
      end
      rmdd_pkg::ST_MUL: begin
        cmd.mul_step = 1'b1;
        cnt_next     = cnt + 1'b1;
        if (cnt_last) begin
          state_next = rmdd_pkg::ST_ROUND;
        end
      end
      rmdd_pkg::ST_ROUND: begin
        cmd.round  = 1'b1;
        state_next = rmdd_pkg::ST_SAT;
      end
      rmdd_pkg::ST_SAT: begin
        cmd.sat    = 1'b1;
        state_next = rmdd_pkg::ST_SCALE;
      end
      rmdd_pkg::ST_SCALE: begin
        cmd.scale  = 1'b1;
        state_next = rmdd_pkg::ST_PRE;
      end
      rmdd_pkg::ST_PRE: begin
        cmd.pre    = 1'b1;
        cnt_next   = '0;
        state_next = rmdd_pkg::ST_DIV;
      end
      rmdd_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        cnt_next     = cnt + 1'b1;
        if (cnt_last) begin
          state_next = rmdd_pkg::ST_DONE;
        end
      end
      rmdd_pkg::ST_DONE: begin
        if (!status.out_full) begin
          cmd.finish = 1'b1;
          state_next = rmdd_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = rmdd_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

>>> design/rmdd_dp.sv
// Datapath: capital/peak/worst state, shift-add multiplier, rounding and
// saturation, drawdown scaling, restoring divider, output register. Uses rmdd_pkg.
module rmdd_dp #(
  parameter int CAPITAL_BITS     = rmdd_pkg::CAPITAL_BITS,
  parameter int RETURN_FRAC_BITS = rmdd_pkg::RETURN_FRAC_BITS
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  rmdd_pkg::cmd_t                          cmd,
  output rmdd_pkg::status_t                       status,
  input  logic [rmdd_pkg::INIT_BITS-1:0]          initial_capital,
  input  logic signed [rmdd_pkg::RETURN_BITS-1:0] trade_return,
  input  logic                                    first_of_series,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic signed [CAPITAL_BITS-1:0]          capital_now,
  output logic [rmdd_pkg::DRAWDOWN_BITS-1:0]      max_drawdown
);

  localparam int CB       = CAPITAL_BITS;
  localparam int FB       = rmdd_pkg::FMAG_BITS;
  localparam int DB       = rmdd_pkg::DRAWDOWN_BITS;
  localparam int PROD_W   = CB + FB;
  localparam int MAG_W    = PROD_W - RETURN_FRAC_BITS;
  localparam int SCALED_W = CB + 7;
  localparam int CMP_W    = (CB > rmdd_pkg::INIT_BITS) ? CB : rmdd_pkg::INIT_BITS;
  localparam logic [CB-1:0] CAP_POS_MAX = {1'b0, {(CB-1){1'b1}}};

  // architectural state
  logic signed [CB-1:0]  cap;
  logic signed [CB-1:0]  peak;
  logic [DB-1:0]         worst;
  logic                  fresh;

  // work registers
  logic [CB-1:0]         capmag;
  logic [FB-1:0]         fmag;
  logic                  neg;
  logic [PROD_W-1:0]     acc;
  logic [MAG_W-1:0]      mag;
  logic [SCALED_W-1:0]   scaled;
  logic                  peak_pos;
  logic [CB-1:0]         rem;
  logic [DB-1:0]         lowbits;
  logic [DB-1:0]         quo;
  logic                  sat_q;

  logic [CMP_W-1:0]                  init_ext;
  logic signed [CB-1:0]              init_sat;
  logic signed [CB-1:0]              base;
  logic signed [rmdd_pkg::RETURN_BITS:0] factor;
  logic [FB-1:0]                     factor_mag;
  logic                              new_series;
  logic [PROD_W-1:0]                 rnd;
  logic [MAG_W-1:0]                  lim;
  logic [MAG_W-1:0]                  mag_sat;
  logic signed [CB-1:0]              new_cap;
  logic [CB-1:0]                     diff;
  logic [CB-1:0]                     hi_ext;
  logic [CB-1:0]                     trial;
  logic [DB-1:0]                     dd;
  logic [DB-1:0]                     worst_next;

  assign init_ext = CMP_W'(initial_capital);
  assign init_sat = (init_ext > CMP_W'(CAP_POS_MAX)) ? CAP_POS_MAX : CB'(init_ext);

  assign new_series = fresh || first_of_series;
  assign base       = new_series ? init_sat : cap;
  assign factor     = {trade_return[rmdd_pkg::RETURN_BITS-1], trade_return}
                    + ((rmdd_pkg::RETURN_BITS+1)'(1) << RETURN_FRAC_BITS);
  assign factor_mag = factor[rmdd_pkg::RETURN_BITS] ? FB'(-factor) : FB'(factor);

  assign rnd     = acc + (PROD_W'(1) << (RETURN_FRAC_BITS - 1));
  assign lim     = neg ? (MAG_W'(1) << (CB - 1)) : ((MAG_W'(1) << (CB - 1)) - 1'b1);
  assign mag_sat = (mag > lim) ? lim : mag;
  assign new_cap = neg ? -CB'(mag_sat) : CB'(mag_sat);

  assign diff   = CB'(peak - cap);
  assign hi_ext = CB'(scaled[SCALED_W-1:16]);
  assign trial  = {rem[CB-2:0], lowbits[DB-1]};

  assign dd         = sat_q ? '1 : quo;
  assign worst_next = (peak_pos && (dd > worst)) ? dd : worst;

  assign status.out_full = out_valid && !out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      fresh     <= 1'b1;
      cap       <= '0;
      peak      <= '0;
      worst     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.start) begin
        fresh <= 1'b0;
        cap   <= base;
        if (new_series) begin
          peak  <= init_sat;
          worst <= '0;
        end
      end
      if (cmd.sat) begin
        cap <= new_cap;
        if (new_cap > peak) begin
          peak <= new_cap;
        end
      end
      if (cmd.finish) begin
        worst     <= worst_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      capmag <= base[CB-1] ? CB'(-base) : CB'(base);
      fmag   <= factor_mag;
      neg    <= base[CB-1] ^ factor[rmdd_pkg::RETURN_BITS];
      acc    <= '0;
    end
    if (cmd.mul_step) begin
      acc  <= (acc << 1) + (fmag[FB-1] ? PROD_W'(capmag) : PROD_W'(0));
      fmag <= fmag << 1;
    end
    if (cmd.round) begin
      mag <= rnd[PROD_W-1:RETURN_FRAC_BITS];
    end
    if (cmd.scale) begin
      // diff * 100 = diff * (64 + 32 + 4)
      scaled   <= (SCALED_W'(diff) << 6) + (SCALED_W'(diff) << 5) + (SCALED_W'(diff) << 2);
      peak_pos <= (peak != '0);
    end
    if (cmd.pre) begin
      // quotient overflows 32 bits when the upper dividend part reaches the divisor
      sat_q   <= (hi_ext >= CB'(peak));
      rem     <= hi_ext;
      lowbits <= {scaled[15:0], 16'd0};
      quo     <= '0;
    end
    if (cmd.div_step) begin
      lowbits <= lowbits << 1;
      if (trial >= CB'(peak)) begin
        rem <= trial - CB'(peak);
        quo <= {quo[DB-2:0], 1'b1};
      end else begin
        rem <= trial;
        quo <= {quo[DB-2:0], 1'b0};
      end
    end
    if (cmd.finish) begin
      capital_now  <= cap;
      max_drawdown <= worst_next;
    end
  end

endmodule

>>> design/running_max_drawdown.sv
// Each input transfer runs 32 multiply steps, round, saturate, scale and divide
// preload steps, 32 divide steps and a result write that waits while the result is full.
// A new item is taken only once the sequencer is idle again, as the bit-serial multiplier and the
// restoring divider share one sequencer; the result register frees input.
// Reset (rst, synchronous): sequencer idle, result empty, initial_capital to
// 65536000, and the first item after reset starts a new series.
`include "assert_macros.svh"

module running_max_drawdown #(
  parameter int CAPITAL_BITS     = rmdd_pkg::CAPITAL_BITS,
  parameter int RETURN_FRAC_BITS = rmdd_pkg::RETURN_FRAC_BITS
) (
  input  logic                           clk,
  input  logic                           rst,
  rmdd_trade_if.sink                     trade,
  rmdd_result_if.source                  result,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [rmdd_pkg::PADDR_W-1:0]   paddr,
  input  logic [rmdd_pkg::PDATA_W-1:0]   pwdata,
  output logic [rmdd_pkg::PDATA_W-1:0]   prdata,
  output logic                           pready
);

  rmdd_pkg::cmd_t                       cmd;
  rmdd_pkg::status_t                    status;
  logic [rmdd_pkg::INIT_BITS-1:0]       initial_capital;

  rmdd_cfg u_cfg (
    .clk             (clk),
    .rst             (rst),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .initial_capital (initial_capital)
  );

  rmdd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (trade.valid),
    .in_ready (trade.ready),
    .status   (status),
    .cmd      (cmd)
  );

  rmdd_dp #(
    .CAPITAL_BITS     (CAPITAL_BITS),
    .RETURN_FRAC_BITS (RETURN_FRAC_BITS)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .status          (status),
    .initial_capital (initial_capital),
    .trade_return    (trade.trade_return),
    .first_of_series (trade.first_of_series),
    .out_valid       (result.valid),
    .out_ready       (result.ready),
    .capital_now     (result.capital_now),
    .max_drawdown    (result.max_drawdown)
  );

  `RMDD_ASSERT_NOW(a_cmd_onehot, clk, rst, 1'b1, $onehot0(cmd))
  `RMDD_ASSERT_NEXT(a_busy_after_transfer, clk, rst, trade.valid && trade.ready, !trade.ready)
  `RMDD_ASSERT_NOW(a_finish_slot_free, clk, rst, cmd.finish, !(result.valid && !result.ready))
  `RMDD_ASSERT_NEXT(a_finish_shows_result, clk, rst, cmd.finish, result.valid)

endmodule

>>> tb/tb_top.sv
// Self-checking testbench for running_max_drawdown: trade returns in, capital
// and running max drawdown out, checked against a bit-exact predictor.
// Depends on rmdd_pkg, rmdd_trade_if, rmdd_result_if and the block itself.
module tb_top;
  import rmdd_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int SETTLE_CYCLES  = 80;
  localparam int HOLD_CYCLES    = 400;
  localparam int RANDOM_PHASES  = 5;
  localparam int PHASE_ITEMS    = 240;

  localparam logic [127:0] CAP_POS_MAG = (128'd1 << (CAPITAL_BITS - 1)) - 128'd1;
  localparam logic [127:0] CAP_NEG_MAG = 128'd1 << (CAPITAL_BITS - 1);
  localparam logic [127:0] DD_SCALE    = 128'd6553600;
  localparam logic [127:0] DD_MAX      = 128'hFFFF_FFFF;
  localparam logic [PADDR_W-1:0] ADDR_INITIAL_CAPITAL = {REG_INITIAL_CAPITAL, 3'b000};

  localparam logic signed [RETURN_BITS-1:0] RET_ONE  = 32'sd1 <<< RETURN_FRAC_BITS;
  localparam logic signed [RETURN_BITS-1:0] RET_HALF = 32'sd1 <<< (RETURN_FRAC_BITS - 1);
  localparam logic signed [RETURN_BITS-1:0] RET_MAX  = 32'sh7FFF_FFFF;
  localparam logic signed [RETURN_BITS-1:0] RET_MIN  = 32'sh8000_0000;

  typedef struct packed {
    logic signed [CAPITAL_BITS-1:0]  capital;
    logic        [DRAWDOWN_BITS-1:0] drawdown;
  } capital_mark_t;

  logic clk = 1'b0;
  logic rst;
  logic psel, penable, pwrite, pready;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata, prdata;

  rmdd_trade_if  trade_ch ();
  rmdd_result_if result_ch ();

  running_max_drawdown dut (
    .clk     (clk),
    .rst     (rst),
    .trade   (trade_ch),
    .result  (result_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // predictor state
  logic signed [CAPITAL_BITS-1:0]  book_capital  = '0;
  logic signed [CAPITAL_BITS-1:0]  book_peak     = '0;
  logic        [DRAWDOWN_BITS-1:0] book_worst    = '0;
  logic                            series_fresh  = 1'b1;
  logic        [INIT_BITS-1:0]     start_capital = INIT_RESET;

  capital_mark_t open_marks[$];
  int  mismatches = 0;
  bit  send_gaps;
  bit  rcv_gaps;
  int  hold_cycles;

  function automatic capital_mark_t mark_trade(input logic signed [RETURN_BITS-1:0] rtn,
                                               input logic restart);
    capital_mark_t mark;
    logic signed [127:0] factor, prod;
    logic [127:0] mag, rounded, lim, diff, quot;
    logic [DRAWDOWN_BITS-1:0] dd;
    logic neg;
    if (series_fresh || restart) begin
      book_capital = CAPITAL_BITS'(start_capital);
      book_peak    = CAPITAL_BITS'(start_capital);
      book_worst   = '0;
      series_fresh = 1'b0;
    end
    factor  = $signed(128'(rtn)) + (128'sd1 <<< RETURN_FRAC_BITS);
    prod    = $signed(128'(book_capital)) * factor;
    neg     = prod[127];
    mag     = neg ? 128'(-prod) : 128'(prod);
    rounded = (mag + (128'd1 << (RETURN_FRAC_BITS - 1))) >> RETURN_FRAC_BITS;
    lim     = neg ? CAP_NEG_MAG : CAP_POS_MAG;
    if (rounded > lim) rounded = lim;
    book_capital = neg ? -CAPITAL_BITS'(rounded) : CAPITAL_BITS'(rounded);
    if (book_capital > book_peak) book_peak = book_capital;
    if (book_peak > 0) begin
      diff = 128'($signed(128'(book_peak)) - $signed(128'(book_capital)));
      quot = (diff * DD_SCALE) / 128'(book_peak);
      dd   = (quot > DD_MAX) ? '1 : quot[DRAWDOWN_BITS-1:0];
      if (dd > book_worst) book_worst = dd;
    end
    mark.capital  = book_capital;
    mark.drawdown = book_worst;
    return mark;
  endfunction

  task automatic flag_mismatch(input string field, input logic [127:0] want,
                               input logic [127:0] got);
    $display("[%0t] mismatch on %s: want 0x%0h got 0x%0h", $time, field, want, got);
    mismatches++;
  endtask

  // result check first, then record the trade accepted at the same edge
  always @(posedge clk) begin
    capital_mark_t want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (open_marks.size() == 0) begin
        flag_mismatch("outstanding results", 128'd1, 128'd0);
      end else begin
        want = open_marks.pop_front();
        if (result_ch.capital_now !== want.capital)
          flag_mismatch("capital_now", want.capital, result_ch.capital_now);
        if (result_ch.max_drawdown !== want.drawdown)
          flag_mismatch("max_drawdown", want.drawdown, result_ch.max_drawdown);
      end
    end
    if (!rst && trade_ch.valid && trade_ch.ready)
      open_marks.insert(open_marks.size(),
                        mark_trade(trade_ch.trade_return, trade_ch.first_of_series));
  end

  // result sink: random stalls, plus one long hold-off on request
  initial begin
    int stall;
    result_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        result_ch.ready <= 1'b0;
        repeat (hold_cycles) @(negedge clk);
        hold_cycles = 0;
      end
      stall = rcv_gaps ? $urandom_range(0, 9) : 0;
      if (stall > 0) begin
        result_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      result_ch.ready <= 1'b1;
      do @(posedge clk); while (!result_ch.valid);
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || (trade_ch.valid && trade_ch.ready) || (result_ch.valid && result_ch.ready)
          || (psel && penable))
        quiet = 0;
      else
        quiet++;
    end
    $display("Regression FAIL");
    $finish;
  end

  task automatic send_trade(input logic signed [RETURN_BITS-1:0] rtn, input logic restart);
    int gap;
    gap = send_gaps ? $urandom_range(0, 9) : 0;
    @(negedge clk);
    if (gap > 0) begin
      trade_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    trade_ch.valid           <= 1'b1;
    trade_ch.trade_return    <= rtn;
    trade_ch.first_of_series <= restart;
    do @(posedge clk); while (!trade_ch.ready);
  endtask

  task automatic settle_block();
    @(negedge clk);
    trade_ch.valid <= 1'b0;
    while (open_marks.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_start_capital(input logic [INIT_BITS-1:0] value);
    logic [PDATA_W-1:0] readback;
    settle_block();
    @(negedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= ADDR_INITIAL_CAPITAL;
    pwdata  <= PDATA_W'(value);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    start_capital = value;
    @(negedge clk);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    readback = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (readback !== PDATA_W'(value))
      flag_mismatch("initial_capital readback", value, readback);
  endtask

  function automatic logic signed [RETURN_BITS-1:0] draw_return();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 70) return RETURN_BITS'(int'($urandom_range(0, 3355444)) - 1677722);
    if (sel < 85) return RETURN_BITS'(int'($urandom_range(0, 1 << 25)) - (1 << 24));
    if (sel < 95) return RETURN_BITS'($urandom());
    return sel[0] ? '0 : -RET_ONE;
  endfunction

  // default capital straight out of reset
  task automatic test_compound_basics();
    send_trade('0, 1'b1);
    send_trade(RET_ONE, 1'b0);
    send_trade(-RET_HALF, 1'b0);
    send_trade(RET_MAX, 1'b0);
    send_trade(RET_MIN, 1'b0);          // factor below zero, capital turns negative
    send_trade(-RET_ONE, 1'b1);         // exactly -100%
    send_trade('0, 1'b0);
    send_trade(-RET_ONE - RET_HALF, 1'b1);
  endtask

  task automatic test_rounding_ties();
    write_start_capital(INIT_BITS'(1));
    send_trade(RET_HALF, 1'b1);
    send_trade(-RET_ONE - RET_HALF, 1'b1);
    send_trade(RET_HALF >>> 1, 1'b1);
    send_trade(-RET_HALF, 1'b1);
  endtask

  task automatic test_capital_saturation();
    write_start_capital('1);
    send_trade(RET_ONE, 1'b1);
    send_trade(RET_MIN, 1'b1);
    send_trade('1, 1'b1);
    send_trade('0, 1'b0);
  endtask

  // peak never positive: drawdown must hold
  task automatic test_zero_peak();
    write_start_capital('0);
    send_trade(RET_ONE, 1'b1);
    send_trade(RET_MAX, 1'b0);
    send_trade(RET_MIN, 1'b0);
  endtask

  task automatic test_backpressure_fill();
    write_start_capital(INIT_RESET);
    send_gaps   = 1'b0;
    hold_cycles = HOLD_CYCLES;
    for (int i = 0; i < 12; i++) send_trade(draw_return(), i == 0);
    settle_block();
    send_gaps = 1'b1;
  endtask

  task automatic test_random_series();
    logic [INIT_BITS-1:0] capital;
    int sent, len;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0: capital = INIT_RESET;
        1: capital = INIT_BITS'($urandom_range(1, 65535));
        2: capital = {15'($urandom()), 32'($urandom())};
        3: capital = '1;
        default: capital = INIT_BITS'(1);
      endcase
      write_start_capital(capital);
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        len = $urandom_range(1, 30);
        send_gaps = $urandom_range(0, 3) != 0;
        rcv_gaps  = $urandom_range(0, 3) != 0;
        for (int i = 0; i < len; i++) begin
          send_trade(draw_return(), (i == 0) ? ($urandom_range(0, 9) != 0)
                                             : ($urandom_range(0, 49) == 0));
          sent++;
        end
      end
    end
    send_gaps = 1'b1;
    rcv_gaps  = 1'b1;
  endtask

  initial begin
    rst                      = 1'b1;
    psel                     = 1'b0;
    penable                  = 1'b0;
    pwrite                   = 1'b0;
    paddr                    = '0;
    pwdata                   = '0;
    trade_ch.valid           = 1'b0;
    trade_ch.trade_return    = '0;
    trade_ch.first_of_series = 1'b0;
    send_gaps                = 1'b1;
    rcv_gaps                 = 1'b1;
    hold_cycles              = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_compound_basics();
    test_rounding_ties();
    test_capital_saturation();
    test_zero_peak();
    test_backpressure_fill();
    test_random_series();
    settle_block();

    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
